// ===== rtl/jdh_pkg.sv =====
// Package for the joystick direction decoder: sizes, register codes, axis states,
// direction codes and the direction lookup. Depends on nothing.
package jdh_pkg;

	localparam int SAMPLES_PER_READING = 8;
	localparam int SAMPLE_W = 12;
	localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING);
	localparam int COUNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
	localparam int DIR_W = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IDLE_LOW,
		REG_IDLE_HIGH,
		REG_LOW_BARRIER,
		REG_HIGH_BARRIER
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] idle_low;
		logic [SAMPLE_W-1:0] idle_high;
		logic [SAMPLE_W-1:0] low_barrier;
		logic [SAMPLE_W-1:0] high_barrier;
	} cfg_t;

	localparam logic [SAMPLE_W-1:0] IDLE_LOW_RST = SAMPLE_W'(28);
	localparam logic [SAMPLE_W-1:0] IDLE_HIGH_RST = SAMPLE_W'(32);
	localparam logic [SAMPLE_W-1:0] LOW_BARRIER_RST = SAMPLE_W'(27);
	localparam logic [SAMPLE_W-1:0] HIGH_BARRIER_RST = SAMPLE_W'(33);

	typedef struct packed {
		logic [SAMPLE_W-1:0] x_avg;
		logic [SAMPLE_W-1:0] y_avg;
	} reading_t;

	typedef enum logic [1:0] {
		AX_IDLE,
		AX_LOW,
		AX_HIGH
	} axis_t;

	localparam logic [DIR_W-1:0] DIR_IDLE = DIR_W'(0);
	localparam logic [DIR_W-1:0] DIR_UP = DIR_W'(1);
	localparam logic [DIR_W-1:0] DIR_UP_RIGHT = DIR_W'(2);
	localparam logic [DIR_W-1:0] DIR_RIGHT = DIR_W'(3);
	localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = DIR_W'(4);
	localparam logic [DIR_W-1:0] DIR_DOWN = DIR_W'(5);
	localparam logic [DIR_W-1:0] DIR_DOWN_LEFT = DIR_W'(6);
	localparam logic [DIR_W-1:0] DIR_LEFT = DIR_W'(7);
	localparam logic [DIR_W-1:0] DIR_UP_LEFT = DIR_W'(8);

	// On X the low side is right; on Y the low side is up.
	function automatic logic [DIR_W-1:0] dir_code(axis_t x_st, axis_t y_st);
		logic [DIR_W-1:0] code;
		case (y_st)
			AX_LOW: begin
				case (x_st)
					AX_LOW: code = DIR_UP_RIGHT;
					AX_HIGH: code = DIR_UP_LEFT;
					default: code = DIR_UP;
				endcase
			end
			AX_HIGH: begin
				case (x_st)
					AX_LOW: code = DIR_DOWN_RIGHT;
					AX_HIGH: code = DIR_DOWN_LEFT;
					default: code = DIR_DOWN;
				endcase
			end
			default: begin
				case (x_st)
					AX_LOW: code = DIR_RIGHT;
					AX_HIGH: code = DIR_LEFT;
					default: code = DIR_IDLE;
				endcase
			end
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/jdh_if.sv =====
// Handshake interfaces for the sample and result channels of the joystick decoder.
// Depends on jdh_pkg for the field widths.
interface jdh_sample_if import jdh_pkg::*;;
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] x_sample;
	logic [SAMPLE_W-1:0] y_sample;

	modport source (output valid, output x_sample, output y_sample, input ready);
	modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

interface jdh_result_if import jdh_pkg::*;;
	logic valid;
	logic ready;
	logic [DIR_W-1:0] direction;
	logic [SAMPLE_W-1:0] x_average;
	logic [SAMPLE_W-1:0] y_average;

	modport source (output valid, output direction, output x_average, output y_average,
		input ready);
	modport sink (input valid, input direction, input x_average, input y_average,
		output ready);
endinterface

// ===== rtl/jdh_accum.sv =====
// Sample accumulator: sums X and Y over one reading and registers the two averages.
// Depends on jdh_pkg.
module jdh_accum import jdh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [SAMPLE_W-1:0] x_sample,
	input  logic [SAMPLE_W-1:0] y_sample,
	input  logic                take,
	output reading_t            rd_s1,
	output logic                rd_valid_s1
);

	logic [SUM_W-1:0]   x_sum_q;
	logic [SUM_W-1:0]   y_sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   x_sum_next;
	logic [SUM_W-1:0]   y_sum_next;
	logic               last;

	assign x_sum_next = x_sum_q + SUM_W'(x_sample);
	assign y_sum_next = y_sum_q + SUM_W'(y_sample);
	assign last = (count_q == COUNT_W'(SAMPLES_PER_READING - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_sum_q <= '0;
			y_sum_q <= '0;
			count_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				rd_valid_s1 <= 1'b0;
			end
			if (in_fire) begin
				if (last) begin
					x_sum_q <= '0;
					y_sum_q <= '0;
					count_q <= '0;
					rd_valid_s1 <= 1'b1;
				end else begin
					x_sum_q <= x_sum_next;
					y_sum_q <= y_sum_next;
					count_q <= count_q + COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last) begin
			rd_s1.x_avg <= SAMPLE_W'(x_sum_next / SUM_W'(SAMPLES_PER_READING));
			rd_s1.y_avg <= SAMPLE_W'(y_sum_next / SUM_W'(SAMPLES_PER_READING));
		end
	end

endmodule

// ===== rtl/jdh_axis.sv =====
// Three-state hysteresis machine for one joystick axis.
// Depends on jdh_pkg for the axis states and the threshold registers.
module jdh_axis import jdh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [SAMPLE_W-1:0] avg,
	input  cfg_t                cfg,
	output axis_t               state_q,
	output axis_t               state_next
);

	logic in_window;
	logic at_low;
	logic at_high;

	assign in_window = (avg > cfg.idle_low) && (avg < cfg.idle_high);
	assign at_low = (avg <= cfg.low_barrier);
	assign at_high = (avg >= cfg.high_barrier);

	// The idle window wins from an active side; the low barrier wins from idle.
	always_comb begin
		unique case (state_q)
			AX_LOW: begin
				if (in_window) state_next = AX_IDLE;
				else if (at_high) state_next = AX_HIGH;
				else state_next = AX_LOW;
			end
			AX_HIGH: begin
				if (in_window) state_next = AX_IDLE;
				else if (at_low) state_next = AX_LOW;
				else state_next = AX_HIGH;
			end
			default: begin
				if (at_low) state_next = AX_LOW;
				else if (at_high) state_next = AX_HIGH;
				else state_next = AX_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AX_IDLE;
		end else if (load) begin
			state_q <= state_next;
		end
	end

endmodule

// ===== rtl/joystick_direction_hysteresis.sv =====
// Top level of the joystick direction decoder: configuration registers, the
// accumulator, the two axis machines and the result register.
// Depends on jdh_pkg, jdh_if, jdh_accum and jdh_axis.
//
// The samples channel takes one X/Y sample pair per transaction and can accept one
// transaction in every clock cycle unless a completed reading cannot move on. Every
// SAMPLES_PER_READING transactions form one reading: the two sums are averaged, each
// axis machine steps once, and one result transaction carries the direction code and
// both averages on the results channel. Other sample transactions produce no result.
// Order: the edge that accepts the last sample pair of a reading loads the average
// register, and the result register is loaded from it once the result register is
// empty or its transaction is taken, which presents the result transaction.
// Throughput: one sample pair per cycle while samples ready is high, one result per reading.
// When the receiver stalls, the result register holds its transaction and the average
// register holds the next reading. While that reading cannot move on, the samples
// channel deasserts ready for every sample pair, including those that would not
// complete a reading. Reset clears the sums, the sample count, both axis machines and
// the result valid, and loads the threshold registers with their defaults. Registers
// are written through cfg_wr_en, cfg_index and cfg_data; the user must write them only
// while no reading is in flight, and the block itself does not enforce this.
module joystick_direction_hysteresis import jdh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	jdh_sample_if.sink             samples,
	jdh_result_if.source           results,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t             cfg_q;
	reading_t         rd_s1;
	logic             rd_valid_s1;
	logic             s2_load;
	logic             in_fire;
	axis_t            x_st_q;
	axis_t            y_st_q;
	axis_t            x_st_next;
	axis_t            y_st_next;
	logic             out_valid_q;
	logic [DIR_W-1:0] direction_q;
	logic [SAMPLE_W-1:0] x_average_q;
	logic [SAMPLE_W-1:0] y_average_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_low <= IDLE_LOW_RST;
			cfg_q.idle_high <= IDLE_HIGH_RST;
			cfg_q.low_barrier <= LOW_BARRIER_RST;
			cfg_q.high_barrier <= HIGH_BARRIER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IDLE_LOW: cfg_q.idle_low <= SAMPLE_W'(cfg_data);
				REG_IDLE_HIGH: cfg_q.idle_high <= SAMPLE_W'(cfg_data);
				REG_LOW_BARRIER: cfg_q.low_barrier <= SAMPLE_W'(cfg_data);
				REG_HIGH_BARRIER: cfg_q.high_barrier <= SAMPLE_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign s2_load = rd_valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !rd_valid_s1 || s2_load;
	assign in_fire = samples.valid && samples.ready;

	jdh_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.x_sample   (samples.x_sample),
		.y_sample   (samples.y_sample),
		.take       (s2_load),
		.rd_s1      (rd_s1),
		.rd_valid_s1(rd_valid_s1)
	);

	jdh_axis u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s2_load),
		.avg       (rd_s1.x_avg),
		.cfg       (cfg_q),
		.state_q   (x_st_q),
		.state_next(x_st_next)
	);

	jdh_axis u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s2_load),
		.avg       (rd_s1.y_avg),
		.cfg       (cfg_q),
		.state_q   (y_st_q),
		.state_next(y_st_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			direction_q <= dir_code(x_st_next, y_st_next);
			x_average_q <= rd_s1.x_avg;
			y_average_q <= rd_s1.y_avg;
		end
	end

	assign results.valid = out_valid_q;
	assign results.direction = direction_q;
	assign results.x_average = x_average_q;
	assign results.y_average = y_average_q;

	// A presented result is the idle code exactly when both axis states it came from are idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((direction_q == DIR_IDLE) ==
			(x_st_q == AX_IDLE && y_st_q == AX_IDLE)))
		else $error("direction code disagrees with axis states");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (direction_q <= DIR_UP_LEFT))
		else $error("direction code out of range");

	// A completed reading that cannot move on must still be held, unchanged, in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid_s1 && !s2_load) |=> (rd_valid_s1 && $stable(rd_s1)))
		else $error("pending reading lost or overwritten");

	// The axis machines only step when a result is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s2_load |=> ($stable(x_st_q) && $stable(y_st_q)))
		else $error("axis state changed without a reading");

endmodule
